// File: sv/gwf_pkg.sv
// Shared types and constants for the groundwater flux stencil.
// Used by the controller, the datapath and the serial multiply/divide unit.
package gwf_pkg;

    // serial arithmetic unit sizes
    localparam int A_W       = 97;   // multiplicand / dividend magnitude
    localparam int B_W       = 50;   // multiplier / divisor magnitude
    localparam int P_W       = 128;  // product register
    localparam int CNT_W     = 7;
    localparam int MUL_STEPS = B_W;
    localparam int DIV_STEPS = A_W;

    // stencil roles
    localparam logic [2:0] ROLE_CENTRE = 3'd0;
    localparam logic [2:0] ROLE_RIGHT  = 3'd2;
    localparam logic [2:0] ROLE_TOP    = 3'd4;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } uop_t;

    typedef enum logic [2:0] {
        CFG_DX = 3'd0,
        CFG_DY = 3'd1,
        CFG_DZ = 3'd2,
        CFG_DT = 3'd3,
        CFG_SY = 3'd4,
        CFG_AD = 3'd5
    } cfg_idx_t;

    // program of the top-item evaluation, one unit operation per step
    typedef enum logic [4:0] {
        STEP_TXM, STEP_TYM,
        STEP_TL, STEP_ML, STEP_DL,
        STEP_TR, STEP_MR, STEP_DR,
        STEP_TD, STEP_MD, STEP_DD,
        STEP_TT, STEP_MT, STEP_DT,
        STEP_XR, STEP_XL, STEP_YT, STEP_YD,
        STEP_CXM, STEP_CXD, STEP_CYM, STEP_CYD,
        STEP_CSM, STEP_CSY,
        STEP_ST, STEP_DX, STEP_DY
    } step_t;

    typedef struct packed {
        logic  latch;
        logic  prep;
        logic  store;
        logic  start;
        logic  commit;
        logic  load_out;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic item_ok;
        logic item_top;
        logic unit_done;
        logic out_free;
    } sts_t;

endpackage

// File: sv/gwf_muldiv.sv
// Shared serial arithmetic unit: shift-add multiply and restoring divide.
// One bit per cycle. Depends on gwf_pkg.
module gwf_muldiv (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  gwf_pkg::uop_t             op,
    input  logic                      neg,
    input  logic [gwf_pkg::A_W-1:0]   a,
    input  logic [gwf_pkg::B_W-1:0]   b,
    output logic                      done,
    output logic [gwf_pkg::P_W-1:0]   result
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [gwf_pkg::CNT_W-1:0]     cnt_reg;
    gwf_pkg::uop_t                 op_reg;
    logic                          neg_reg;
    logic [gwf_pkg::P_W-1:0]       acc_reg;
    logic [gwf_pkg::P_W-1:0]       mc_reg;
    logic [gwf_pkg::B_W-1:0]       mp_reg;
    logic [gwf_pkg::B_W-1:0]       rem_reg;

    logic [gwf_pkg::B_W:0]         r2;
    logic                          qbit;
    logic [gwf_pkg::B_W-1:0]       rem_next;

    always_comb begin
        r2 = {rem_reg, mc_reg[gwf_pkg::A_W-1]};
        qbit = (r2 >= {1'b0, mp_reg});
        rem_next = qbit ? gwf_pkg::B_W'(r2 - {1'b0, mp_reg}) : r2[gwf_pkg::B_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == gwf_pkg::CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (op == gwf_pkg::UOP_MUL) ? gwf_pkg::CNT_W'(gwf_pkg::MUL_STEPS)
                                                      : gwf_pkg::CNT_W'(gwf_pkg::DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - gwf_pkg::CNT_W'(1);
                if (cnt_reg == gwf_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg  <= op;
            neg_reg <= neg;
            acc_reg <= '0;
            mc_reg  <= gwf_pkg::P_W'(a);
            mp_reg  <= b;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (op_reg == gwf_pkg::UOP_MUL) begin
                if (mp_reg[0]) begin
                    acc_reg <= acc_reg + mc_reg;
                end
                mc_reg <= {mc_reg[gwf_pkg::P_W-2:0], 1'b0};
                mp_reg <= {1'b0, mp_reg[gwf_pkg::B_W-1:1]};
            end else begin
                rem_reg <= rem_next;
                mc_reg  <= gwf_pkg::P_W'({mc_reg[gwf_pkg::A_W-2:0], qbit});
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == gwf_pkg::UOP_MUL)
                    ? (neg_reg ? (~acc_reg + gwf_pkg::P_W'(1)) : acc_reg)
                    : gwf_pkg::P_W'(mc_reg[gwf_pkg::A_W-1:0]);

endmodule

// File: sv/gwf_datapath.sv
// Datapath: configuration registers, stencil stores, work registers and output register.
// Depends on gwf_pkg and gwf_muldiv.
module gwf_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  gwf_pkg::cmd_t       cmd,
    output gwf_pkg::sts_t       sts,
    input  logic [191:0]        s_tdata,
    input  logic [2:0]          s_tuser,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,
    output logic                m_tuser
);

    function automatic logic signed [47:0] sat48(input logic signed [127:0] v);
        if (v[127:47] == {81{v[47]}}) begin
            return v[47:0];
        end
        return v[127] ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
    endfunction

    function automatic logic [96:0] mag98(input logic signed [97:0] v);
        logic signed [97:0] t;
        t = v[97] ? -v : v;
        return t[96:0];
    endfunction

    function automatic logic [49:0] mag51(input logic signed [50:0] v);
        logic signed [50:0] t;
        t = v[50] ? -v : v;
        return t[49:0];
    endfunction

    // configuration
    logic [31:0] dx_reg, dy_reg, dz_reg, dt_reg, ad_reg;
    logic [16:0] sy_reg;

    // latched item
    logic [2:0]         role_reg;
    logic signed [31:0] np_reg, opr_reg;
    logic [31:0]        zf_reg, px_reg, py_reg;
    logic               dneg_reg;
    logic [47:0]        zprod_reg;

    // stencil stores
    logic signed [47:0] hs_reg [5];
    logic [31:0]        ps_reg [5];
    logic [31:0]        cpy_reg;
    logic signed [47:0] oldh_reg;
    logic [3:0]         edge_reg;

    // work registers
    logic signed [47:0]  txm_reg, tym_reg, tn_reg, txl_reg, txr_reg, tyd_reg, tyt_reg;
    logic signed [97:0]  xs_reg, ys_reg;
    logic [31:0]         cx_reg, cy_reg, cs_reg;
    logic signed [109:0] acc_reg;
    logic [127:0]        prod_reg;

    // output
    logic        mv_reg;
    logic [47:0] flux_reg;
    logic        clip_reg;

    // unit
    gwf_pkg::uop_t u_op;
    logic          u_neg;
    logic [96:0]   u_a;
    logic [49:0]   u_b;
    logic          u_done;
    logic [127:0]  u_res;

    gwf_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .op      (u_op),
        .neg     (u_neg),
        .a       (u_a),
        .b       (u_b),
        .done    (u_done),
        .result  (u_res)
    );

    // heads of the latched item
    logic [47:0]        off;
    logic signed [47:0] head_new, head_old;
    logic [1:0]         em_idx;

    always_comb begin
        logic [48:0] osum;
        osum     = {1'b0, ad_reg} + {1'b0, zprod_reg};
        off      = osum[48:1];
        head_new = sat48(128'($signed(50'(np_reg) + $signed({2'b00, off}))));
        head_old = sat48(128'($signed(50'(opr_reg) + $signed({2'b00, off}))));
        em_idx   = 2'(role_reg - 3'd1);
    end

    // stencil selections
    logic               el, er, ed, et;
    logic signed [47:0] m, hl, hr, hd, ht;
    logic signed [48:0] dhl, dhr, dhd, dht, dhdt;

    always_comb begin
        logic signed [48:0] dr, dl, dtp, dd;
        el = edge_reg[0];
        er = edge_reg[1];
        ed = edge_reg[2];
        et = edge_reg[3];
        m  = hs_reg[0];
        hl = el ? m : hs_reg[1];
        hr = er ? m : hs_reg[2];
        hd = ed ? m : hs_reg[3];
        ht = et ? m : hs_reg[4];
        dr  = 49'(hr) - 49'(m);
        dl  = 49'(m) - 49'(hl);
        dtp = 49'(ht) - 49'(m);
        dd  = 49'(m) - 49'(hd);
        if (el) begin
            dhr = dr;
            dhl = dr;
        end else if (er) begin
            dhr = dl;
            dhl = dl;
        end else begin
            dhr = dr;
            dhl = dl;
        end
        if (ed) begin
            dht = dtp;
            dhd = dtp;
        end else if (et) begin
            dht = dd;
            dhd = dd;
        end else begin
            dht = dtp;
            dhd = dd;
        end
        dhdt = 49'(m) - 49'(oldh_reg);
    end

    // harmonic mean pieces for the face steps
    logic signed [47:0] tc;
    logic               hedge;
    logic signed [48:0] hsum;
    logic               hneg;
    logic signed [97:0] hq;
    logic signed [47:0] hval;

    always_comb begin
        case (cmd.step)
            gwf_pkg::STEP_ML, gwf_pkg::STEP_DL: begin
                tc = txm_reg;
                hedge = el;
            end
            gwf_pkg::STEP_MR, gwf_pkg::STEP_DR: begin
                tc = txm_reg;
                hedge = er;
            end
            gwf_pkg::STEP_MD, gwf_pkg::STEP_DD: begin
                tc = tym_reg;
                hedge = ed;
            end
            default: begin
                tc = tym_reg;
                hedge = et;
            end
        endcase
        hsum = 49'(tn_reg) + 49'(tc);
        hneg = prod_reg[127] ^ hsum[48];
        hq   = hneg ? -$signed({1'b0, u_res[96:0]}) : $signed({1'b0, u_res[96:0]});
        if (hedge) begin
            hval = tc;
        end else if (hsum == '0) begin
            hval = '0;
        end else begin
            hval = sat48(128'(hq));
        end
    end

    // operand selection
    always_comb begin
        logic signed [97:0] sa;
        logic signed [50:0] sb;
        logic               is_div;
        sa = '0;
        sb = '0;
        is_div = 1'b0;
        u_a = '0;
        u_b = '0;
        case (cmd.step)
            gwf_pkg::STEP_TXM: begin sa = 98'(m);  sb = 51'({1'b0, ps_reg[0]}); end
            gwf_pkg::STEP_TYM: begin sa = 98'(m);  sb = 51'({1'b0, cpy_reg}); end
            gwf_pkg::STEP_TL:  begin sa = 98'(hl); sb = 51'({1'b0, ps_reg[1]}); end
            gwf_pkg::STEP_TR:  begin sa = 98'(hr); sb = 51'({1'b0, ps_reg[2]}); end
            gwf_pkg::STEP_TD:  begin sa = 98'(hd); sb = 51'({1'b0, ps_reg[3]}); end
            gwf_pkg::STEP_TT:  begin sa = 98'(ht); sb = 51'({1'b0, ps_reg[4]}); end
            gwf_pkg::STEP_ML, gwf_pkg::STEP_MR,
            gwf_pkg::STEP_MD, gwf_pkg::STEP_MT: begin
                sa = 98'(tn_reg);
                sb = 51'(tc);
            end
            gwf_pkg::STEP_DL, gwf_pkg::STEP_DR,
            gwf_pkg::STEP_DD, gwf_pkg::STEP_DT: begin
                is_div = 1'b1;
                u_a = mag98($signed({prod_reg[96:0], 1'b0}));
                u_b = mag51(51'(hsum));
            end
            gwf_pkg::STEP_XR: begin sa = 98'(txr_reg); sb = 51'(dhr); end
            gwf_pkg::STEP_XL: begin sa = 98'(txl_reg); sb = 51'(dhl); end
            gwf_pkg::STEP_YT: begin sa = 98'(tyt_reg); sb = 51'(dht); end
            gwf_pkg::STEP_YD: begin sa = 98'(tyd_reg); sb = 51'(dhd); end
            gwf_pkg::STEP_CXM: begin sa = 98'({1'b0, dt_reg}); sb = 51'({1'b0, dy_reg}); end
            gwf_pkg::STEP_CYM: begin sa = 98'({1'b0, dt_reg}); sb = 51'({1'b0, dx_reg}); end
            gwf_pkg::STEP_CXD: begin
                is_div = 1'b1;
                u_a = 97'(prod_reg[63:0]);
                u_b = (dx_reg == '0) ? 50'd1 : 50'(dx_reg);
            end
            gwf_pkg::STEP_CYD: begin
                is_div = 1'b1;
                u_a = 97'(prod_reg[63:0]);
                u_b = (dy_reg == '0) ? 50'd1 : 50'(dy_reg);
            end
            gwf_pkg::STEP_CSM: begin sa = 98'({1'b0, dx_reg}); sb = 51'({1'b0, dy_reg}); end
            gwf_pkg::STEP_CSY: begin sa = 98'({1'b0, cs_reg}); sb = 51'({1'b0, sy_reg}); end
            gwf_pkg::STEP_ST:  begin sa = 98'({1'b0, cs_reg}); sb = 51'(dhdt); end
            gwf_pkg::STEP_DX:  begin
                sa = 98'($signed(xs_reg[97:8]));
                sb = 51'({1'b0, cx_reg});
            end
            gwf_pkg::STEP_DY:  begin
                sa = 98'($signed(ys_reg[97:8]));
                sb = 51'({1'b0, cy_reg});
            end
            default: ;
        endcase
        u_op  = is_div ? gwf_pkg::UOP_DIV : gwf_pkg::UOP_MUL;
        u_neg = sa[97] ^ sb[50];
        if (!is_div) begin
            u_a = mag98(sa);
            u_b = mag51(sb);
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dx_reg <= 32'd65536;
            dy_reg <= 32'd65536;
            dz_reg <= 32'd65536;
            dt_reg <= 32'd65536;
            sy_reg <= 17'd6554;
            ad_reg <= 32'd655360;
        end else if (cfg_valid) begin
            unique case (gwf_pkg::cfg_idx_t'(cfg_index))
                gwf_pkg::CFG_DX: dx_reg <= cfg_data;
                gwf_pkg::CFG_DY: dy_reg <= cfg_data;
                gwf_pkg::CFG_DZ: dz_reg <= cfg_data;
                gwf_pkg::CFG_DT: dt_reg <= cfg_data;
                gwf_pkg::CFG_SY: sy_reg <= cfg_data[16:0];
                gwf_pkg::CFG_AD: ad_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // item latch, depth product, stores
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            role_reg <= s_tuser;
            np_reg   <= s_tdata[31:0];
            opr_reg  <= s_tdata[63:32];
            zf_reg   <= s_tdata[95:64];
            px_reg   <= s_tdata[127:96];
            py_reg   <= s_tdata[159:128];
            dneg_reg <= s_tdata[191];
        end
        if (cmd.prep) begin
            zprod_reg <= 48'((64'(dz_reg) * 64'(zf_reg)) >> 16);
        end
        if (cmd.store && sts.item_ok) begin
            hs_reg[role_reg] <= head_new;
            if (role_reg == gwf_pkg::ROLE_CENTRE) begin
                oldh_reg  <= head_old;
                ps_reg[0] <= px_reg;
                cpy_reg   <= py_reg;
            end else begin
                ps_reg[role_reg] <= (role_reg <= gwf_pkg::ROLE_RIGHT) ? px_reg : py_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg <= '0;
        end else if (cmd.store && sts.item_ok && role_reg != gwf_pkg::ROLE_CENTRE) begin
            edge_reg[em_idx] <= dneg_reg;
        end
    end

    // commit unit results
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            prod_reg <= u_res;
            case (cmd.step)
                gwf_pkg::STEP_TXM: txm_reg <= sat48($signed(u_res) >>> 24);
                gwf_pkg::STEP_TYM: tym_reg <= sat48($signed(u_res) >>> 24);
                gwf_pkg::STEP_TL, gwf_pkg::STEP_TR,
                gwf_pkg::STEP_TD, gwf_pkg::STEP_TT: tn_reg <= sat48($signed(u_res) >>> 24);
                gwf_pkg::STEP_DL: txl_reg <= hval;
                gwf_pkg::STEP_DR: txr_reg <= hval;
                gwf_pkg::STEP_DD: tyd_reg <= hval;
                gwf_pkg::STEP_DT: tyt_reg <= hval;
                gwf_pkg::STEP_XR: xs_reg <= $signed(u_res[97:0]);
                gwf_pkg::STEP_XL: xs_reg <= xs_reg - $signed(u_res[97:0]);
                gwf_pkg::STEP_YT: ys_reg <= $signed(u_res[97:0]);
                gwf_pkg::STEP_YD: ys_reg <= ys_reg - $signed(u_res[97:0]);
                gwf_pkg::STEP_CXD: cx_reg <= (|u_res[96:32]) ? 32'hFFFFFFFF : u_res[31:0];
                gwf_pkg::STEP_CYD: cy_reg <= (|u_res[96:32]) ? 32'hFFFFFFFF : u_res[31:0];
                gwf_pkg::STEP_CSM, gwf_pkg::STEP_CSY:
                    cs_reg <= (|u_res[63:48]) ? 32'hFFFFFFFF : u_res[47:16];
                gwf_pkg::STEP_ST: acc_reg <= $signed(u_res[117:8]);
                gwf_pkg::STEP_DX, gwf_pkg::STEP_DY:
                    acc_reg <= acc_reg - $signed(u_res[125:16]);
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.load_out) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            flux_reg <= sat48(128'(acc_reg));
            clip_reg <= (acc_reg[109:47] != {63{acc_reg[47]}});
        end
    end

    always_comb begin
        sts.item_ok   = (role_reg <= gwf_pkg::ROLE_TOP);
        sts.item_top  = (role_reg == gwf_pkg::ROLE_TOP);
        sts.unit_done = u_done;
        sts.out_free  = !mv_reg || m_tready;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = flux_reg;
    assign m_tuser  = clip_reg;

endmodule

// File: sv/gwf_ctrl.sv
// Controller: item intake and the step sequence of the top-item evaluation.
// Depends on gwf_pkg; drives the datapath through gwf_pkg::cmd_t.
module gwf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  gwf_pkg::sts_t  sts,
    output gwf_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_STORE  = 6'b000100,
        ST_ISSUE  = 6'b001000,
        ST_WAIT   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    gwf_pkg::step_t step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (sts.item_ok && sts.item_top) begin
                    step_next  = gwf_pkg::STEP_TXM;
                    state_next = ST_ISSUE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.unit_done) begin
                    cmd.commit = 1'b1;
                    if (step_reg == gwf_pkg::STEP_DY) begin
                        state_next = ST_FINISH;
                    end else begin
                        step_next  = gwf_pkg::step_t'(5'(step_reg) + 5'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINISH: begin
                // hold until the output register can take the result
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= gwf_pkg::STEP_TXM;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: sv/groundwater_flux_stencil.sv
// Groundwater boundary flux of one surface cell from a five-point stencil.
// Items arrive centre, left, right, down, top; role travels in s_tuser. A centre, left,
// right or down item passes through accept, depth product and store. The top item runs a
// program of 21 multiplies and 6 divides on one shared bit-serial unit, and then one
// Q24.24 flux result with a clip flag leaves through an output register; a new item is
// taken while it waits. Roles five to seven are taken and dropped. Configuration writes
// are always ready.
module groundwater_flux_stencil (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // p_new, p_old, depth_factor, perm_x_value, perm_y_value, domain_top
    input  logic [191:0]  s_tdata,
    // role
    input  logic [2:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // flux
    output logic [47:0]   m_tdata,
    // saturated
    output logic          m_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    gwf_pkg::cmd_t cmd;
    gwf_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    gwf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gwf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: bench/tb.sv
// Self-checking bench for groundwater_flux_stencil: drives stencil items and register
// writes, predicts each flux result and compares it. Depends on gwf_pkg and the RTL.
module tb;

    localparam int WATCH_LIMIT = 30000;
    localparam int HOLD_CYCLES = 5000;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [47:0] q48_t;
    typedef struct {
        logic [2:0]  role;
        logic [31:0] p_new, p_old, zf, kx, ky, dtop;
    } cell_item_t;
    typedef struct {
        logic [47:0] flux;
        logic        clip;
    } flux_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    groundwater_flux_stencil u_top (.*);

    // predictor copy of the block
    logic [31:0] cell_reg [6];
    q48_t        head_mem [5];
    logic [31:0] perm_mem [5];
    logic [31:0] perm_y_mid;
    q48_t        prev_head_c;
    logic [3:0]  missing;

    flux_res_t   flux_q[$];
    int          errors = 0;
    bit          idling = 1'b1;
    bit          hold_rx = 1'b0;
    int          quiet = 0;

    initial forever #5 aclk = ~aclk;

    function automatic q48_t clamp48(input wide_t v, output bit clip);
        wide_t hi, lo;
        hi = (wide_t'(1) <<< 47) - 1;
        lo = -(wide_t'(1) <<< 47);
        clip = 1'b0;
        if (v > hi) begin
            clip = 1'b1;
            return hi[47:0];
        end
        if (v < lo) begin
            clip = 1'b1;
            return lo[47:0];
        end
        return v[47:0];
    endfunction

    function automatic q48_t head_of(input logic [31:0] p, input logic [31:0] zf);
        logic [63:0] off;
        bit c;
        off = ({32'b0, cell_reg[gwf_pkg::CFG_DZ]} * {32'b0, zf}) >> 16;
        off = ({32'b0, cell_reg[gwf_pkg::CFG_AD]} + off) >> 1;
        return clamp48(wide_t'($signed(p)) + wide_t'(off), c);
    endfunction

    function automatic q48_t transmissivity(input q48_t h, input logic [31:0] k);
        bit c;
        return clamp48((wide_t'(h) * wide_t'(k)) >>> 24, c);
    endfunction

    function automatic q48_t harmonic(input q48_t a, input q48_t b);
        wide_t s;
        bit c;
        s = wide_t'(a) + wide_t'(b);
        if (s == 0) return '0;
        return clamp48((wide_t'(2) * wide_t'(a) * wide_t'(b)) / s, c);
    endfunction

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] ratio(input logic [31:0] a, b, c);
        logic [63:0] d;
        d = (c == 0) ? 64'd1 : {32'b0, c};
        return clip32(({32'b0, a} * {32'b0, b}) / d);
    endfunction

    task automatic predict(input cell_item_t it);
        q48_t m, hl, hr, hd, ht, txm, tym, txl, txr, tyd, tyt;
        wide_t dhl, dhr, dhd, dht, dhdt, dxs, dys, acc;
        logic [31:0] cx, cy, cs, area;
        flux_res_t r;
        bit c;
        if (it.role > gwf_pkg::ROLE_TOP) return;
        head_mem[it.role] = head_of(it.p_new, it.zf);
        if (it.role == gwf_pkg::ROLE_CENTRE) begin
            prev_head_c = head_of(it.p_old, it.zf);
            perm_mem[0] = it.kx;
            perm_y_mid = it.ky;
            return;
        end
        perm_mem[it.role] = (it.role <= gwf_pkg::ROLE_RIGHT) ? it.kx : it.ky;
        missing[it.role - 1] = it.dtop[31];
        if (it.role != gwf_pkg::ROLE_TOP) return;

        m = head_mem[0];
        hl = missing[0] ? m : head_mem[1];
        hr = missing[1] ? m : head_mem[2];
        hd = missing[2] ? m : head_mem[3];
        ht = missing[3] ? m : head_mem[4];
        txm = transmissivity(m, perm_mem[0]);
        tym = transmissivity(m, perm_y_mid);
        txl = missing[0] ? txm : harmonic(transmissivity(hl, perm_mem[1]), txm);
        txr = missing[1] ? txm : harmonic(transmissivity(hr, perm_mem[2]), txm);
        tyd = missing[2] ? tym : harmonic(transmissivity(hd, perm_mem[3]), tym);
        tyt = missing[3] ? tym : harmonic(transmissivity(ht, perm_mem[4]), tym);

        dhdt = wide_t'(m) - wide_t'(prev_head_c);
        // a missing side mirrors the gradient of the opposite side
        if (missing[0]) begin
            dhr = wide_t'(hr) - wide_t'(m);
            dhl = dhr;
        end else if (missing[1]) begin
            dhl = wide_t'(m) - wide_t'(hl);
            dhr = dhl;
        end else begin
            dhr = wide_t'(hr) - wide_t'(m);
            dhl = wide_t'(m) - wide_t'(hl);
        end
        if (missing[2]) begin
            dht = wide_t'(ht) - wide_t'(m);
            dhd = dht;
        end else if (missing[3]) begin
            dhd = wide_t'(m) - wide_t'(hd);
            dht = dhd;
        end else begin
            dhd = wide_t'(m) - wide_t'(hd);
            dht = wide_t'(ht) - wide_t'(m);
        end

        cx = ratio(cell_reg[gwf_pkg::CFG_DT], cell_reg[gwf_pkg::CFG_DY],
                   cell_reg[gwf_pkg::CFG_DX]);
        cy = ratio(cell_reg[gwf_pkg::CFG_DT], cell_reg[gwf_pkg::CFG_DX],
                   cell_reg[gwf_pkg::CFG_DY]);
        area = clip32(({32'b0, cell_reg[gwf_pkg::CFG_DX]}
                       * {32'b0, cell_reg[gwf_pkg::CFG_DY]}) >> 16);
        cs = clip32(({32'b0, area} * {32'b0, cell_reg[gwf_pkg::CFG_SY]}) >> 16);

        dxs = wide_t'(txr) * dhr - wide_t'(txl) * dhl;
        dys = wide_t'(tyt) * dht - wide_t'(tyd) * dhd;
        acc = (wide_t'(cs) * dhdt) >>> 8;
        acc = acc - (((dxs >>> 8) * wide_t'(cx)) >>> 16);
        acc = acc - (((dys >>> 8) * wide_t'(cy)) >>> 16);
        r.flux = clamp48(acc, c);
        r.clip = c;
        flux_q.push_back(r);
    endtask

    // send one item; tvalid stays high afterwards unless the next call opens a gap or a drain lowers it
    task automatic send_item(input cell_item_t it);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.role;
        s_tdata <= {it.dtop, it.ky, it.kx, it.zf, it.p_old, it.p_new};
        do @(posedge aclk); while (!s_tready);
        predict(it);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        wait (flux_q.size() == 0);
        repeat (50) @(posedge aclk);
    endtask

    // write all six registers back to back, only while the block is idle
    task automatic write_regs(input logic [31:0] v0, v1, v2, v3, v4, v5);
        logic [31:0] vals [6];
        vals = '{v0, v1, v2, v3, v4, v5};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= gwf_pkg::cfg_idx_t'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            cell_reg[i] = (gwf_pkg::cfg_idx_t'(i) == gwf_pkg::CFG_SY)
                          ? {15'b0, vals[i][16:0]} : vals[i];
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h00FF_FFFF);
            2: return -$urandom_range(0, 32'h00FF_FFFF);
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 32'h0064_0000);
        endcase
    endfunction

    function automatic cell_item_t rand_item(input logic [2:0] role, input bit miss);
        cell_item_t it;
        it.role = role;
        it.p_new = pick_val();
        it.p_old = pick_val();
        it.zf = pick_val();
        it.kx = pick_val();
        it.ky = pick_val();
        it.dtop = miss ? (32'h8000_0000 | $urandom) : (32'h7FFF_FFFF & $urandom);
        return it;
    endfunction

    task automatic send_stencil(input logic [3:0] miss, input bit fill_en,
                                input logic [31:0] fill);
        cell_item_t it;
        for (int r = 0; r <= gwf_pkg::ROLE_TOP; r++) begin
            it = rand_item(r[2:0], (r == 0) ? $urandom_range(0, 1) : miss[r - 1]);
            if (fill_en) begin
                it.p_new = fill;
                it.p_old = ~fill;
                it.zf = fill;
                it.kx = fill;
                it.ky = fill;
            end
            send_item(it);
        end
    endtask

    task automatic send_random(input int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(0, 9))
                7: begin
                    send_item(rand_item($urandom_range(0, 4), $urandom_range(0, 1)));
                    sent++;
                end
                8: send_item(rand_item($urandom_range(5, 7), $urandom_range(0, 1)));
                9: begin
                    send_item(rand_item(gwf_pkg::ROLE_TOP, $urandom_range(0, 1)));
                    sent++;
                end
                default: begin
                    send_stencil(($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0, 1'b0, '0);
                    sent += 5;
                end
            endcase
        end
    endtask

    task automatic test_field_extremes();
        send_stencil(4'h0, 1'b1, 32'h0000_0000);
        send_stencil(4'h0, 1'b1, 32'hFFFF_FFFF);
        send_stencil(4'h0, 1'b1, 32'h8000_0000);
        send_stencil(4'h0, 1'b1, 32'h7FFF_FFFF);
    endtask

    task automatic test_special_cases();
        for (int r = 5; r <= 7; r++) send_item(rand_item(r[2:0], 1'b0));
        send_item(rand_item(gwf_pkg::ROLE_TOP, 1'b0));
        send_stencil(4'hF, 1'b0, '0);
        send_stencil(4'b0011, 1'b0, '0);
        drain_and_settle();
    endtask

    task automatic test_register_extremes();
        write_regs('1, '1, '1, '1, 32'd65536, '1);
        send_random(40);
        drain_and_settle();
        write_regs(32'd1, 32'd1, '0, '0, '0, '0);
        send_random(40);
        drain_and_settle();
        // zero cell widths divide as one LSB; specific yield above one is used as given
        write_regs('0, '0, 32'd65536, 32'd65536, 32'h1FFFF, 32'd655360);
        send_random(40);
        drain_and_settle();
    endtask

    task automatic test_output_backpressure();
        hold_rx = 1'b1;
        for (int i = 0; i < 4; i++) send_stencil(4'h0, 1'b0, '0);
        drain_and_settle();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 4; p++) begin
            write_regs($urandom_range(32'h4000, 32'h40000), $urandom_range(32'h4000, 32'h40000),
                       $urandom, $urandom_range(0, 32'h100000), $urandom_range(0, 65536),
                       $urandom);
            send_random(75);
            drain_and_settle();
        end
        write_regs(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd6554, 32'd655360);
        idling = 1'b0;
        send_random(75);
        drain_and_settle();
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        wait (aresetn);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end else if (idling && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (flux_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual flux %h sat %b",
                         $time, m_tdata, m_tuser);
            end else begin
                if (m_tdata !== flux_q[0].flux) begin
                    errors++;
                    $display("%0t flux mismatch: expected %h, actual %h",
                             $time, flux_q[0].flux, m_tdata);
                end
                if (m_tuser !== flux_q[0].clip) begin
                    errors++;
                    $display("%0t saturated mismatch: expected %b, actual %b",
                             $time, flux_q[0].clip, m_tuser);
                end
                void'(flux_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCH_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        cell_reg = '{32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd6554, 32'd655360};
        missing = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_special_cases();
        test_register_extremes();
        test_output_backpressure();
        test_random_settings();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
